// File: src/motion_urge_match_scorer_top_macros.svh
// Assertion macros shared by the motion urge match scorer RTL.
`ifndef MOTION_URGE_MATCH_SCORER_TOP_MACROS_SVH
`define MOTION_URGE_MATCH_SCORER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define MUS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define MUS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mus_pkg.sv
// Shared types, constants and helper functions of the motion urge match scorer.
`default_nettype none

package mus_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q = 17'(1 << FRAC_BITS);
    localparam logic [16:0] MAX_SAMPLES = 17'd65536;

    // A match below this bar (0.999 scaled by one thousand) counts as unmet.
    localparam logic [26:0] MATCH_SCALE = 27'd1000;
    localparam logic [26:0] MATCH_BAR = 27'(999 * (1 << FRAC_BITS));

    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_CNT_W = 7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_TORQUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_URGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFORT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_WEIGHT = 3'd5;

    typedef struct packed {
        logic signed [31:0] angular_velocity;
        logic signed [31:0] active_drive_torque;
        logic signed [31:0] posture_torque;
        logic signed [31:0] urge_level;
        logic               final_sample;
    } sample_t;

    typedef struct packed {
        logic [31:0]        achieved_rate;
        logic [31:0]        mean_effort;
        logic [31:0]        mean_urge;
        logic [16:0]        match_ratio;
        logic [16:0]        weakest_fraction;
        logic               within_budget;
        logic               budget_limited;
        logic [16:0]        window_total;
        logic signed [31:0] penalized_score;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC,
        ST_TAU_WAIT,
        ST_TAU_ADD,
        ST_SUMS,
        ST_FIN_CHECK,
        ST_W_RNG,
        ST_W_GOT,
        ST_W_GOT_WAIT,
        ST_W_U_WAIT,
        ST_W_MET,
        ST_W_WANTN,
        ST_W_METN,
        ST_W_FRAC_WAIT,
        ST_W_END,
        ST_F_START,
        ST_F_RATE,
        ST_F_RATE_WAIT,
        ST_F_EFF_WAIT,
        ST_F_URGE_WAIT,
        ST_F_MATCH_WAIT,
        ST_F_PEN,
        ST_F_SCORE,
        ST_F_EMIT
    } mus_state_t;

    // Clamp a raw quotient to the 32-bit unsigned range.
    function automatic logic [31:0] sat32(input logic [DIV_NUM_W-1:0] q);
        return (|q[DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Clamp a raw quotient to one in Q16.16.
    function automatic logic [16:0] cap_one(input logic [DIV_NUM_W-1:0] q);
        return (q > DIV_NUM_W'(ONE_Q)) ? ONE_Q : q[16:0];
    endfunction

endpackage

`default_nettype wire

// File: src/mus_sample_if.sv
// Handshake channel that carries one motion sample per transfer.
`default_nettype none

interface mus_sample_if;
    import mus_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/mus_result_if.sv
// Handshake channel that carries one run score per transfer.
`default_nettype none

interface mus_result_if;
    import mus_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/mus_cfg_if.sv
// Register write channel: register index and write data per transfer.
`default_nettype none

interface mus_cfg_if;
    import mus_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/mus_div.sv
// Shared restoring divider, one quotient bit per cycle over a left-justified numerator.
`default_nettype none

module mus_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mus_pkg::DIV_NUM_W-1:0] num,
    input  logic [mus_pkg::DIV_CNT_W-1:0] nbits,
    input  logic [mus_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic                          done,
    output logic [mus_pkg::DIV_NUM_W-1:0] quo
);
    import mus_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 ge;

    assign rem_shift = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign ge        = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            num_next  = num;
            den_next  = den;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: src/mus_mul.sv
// Shared 33 by 32 bit unsigned multiplier with a registered product.
`default_nettype none

module mus_mul (
    input  logic        clk,
    input  logic [32:0] a,
    input  logic [31:0] b,
    output logic [64:0] p
);
    logic [64:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 65'(a) * 65'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: src/motion_urge_match_scorer_top.sv
// Top level of the motion urge match scorer: sequencer, run state and result register.
//
//  Channel  Kind      Payload                                  Transfer when
//  cfg      sink      index (3 bits), data (32 bits)           cfg.valid && cfg.ready
//  sample   sink      four signed Q16.16 values, final flag    sample.valid && sample.ready
//  result   source    rate, effort, urge, match, flags, score  result.valid && result.ready
//
// An ordinary sample keeps the sample channel busy through the
// 49-step torque division in the shared divider; with zero gravity torque it is skipped.
// A sample that closes a sub-window adds divisions of 64, 33 and 48 steps (first and last skippable),
// and the final sample adds divisions of 64, 64, 64 and 80 steps, of which some can be skipped.
// The sample channel is ready only while the sequencer is idle. A finished score waits in the
// result register, so a later final sample stalls until it is taken. Reset loads defaults.
`default_nettype none
`include "motion_urge_match_scorer_top_macros.svh"

module motion_urge_match_scorer_top (
    input  logic                clk,
    input  logic                rst_n,
    mus_cfg_if.sink             cfg,
    mus_sample_if.sink          sample,
    mus_result_if.source        result
);
    import mus_pkg::*;

    // Configuration registers.
    logic [15:0] win_samples_reg;
    logic [31:0] motion_range_reg;
    logic [31:0] gravity_torque_reg;
    logic [31:0] peak_urge_reg;
    logic [31:0] effort_limit_reg;
    logic [31:0] penalty_weight_reg;

    // Sequencer and run state.
    mus_state_t  state_reg, state_next;
    logic [47:0] velocity_total_reg, velocity_total_next;
    logic [63:0] effort_total_reg, effort_total_next;
    logic [16:0] sample_total_reg, sample_total_next;
    logic [15:0] window_fill_reg, window_fill_next;
    logic [47:0] window_velocity_reg, window_velocity_next;
    logic [32:0] window_urge_reg, window_urge_next;
    logic [63:0] met_total_reg, met_total_next;
    logic [63:0] wanted_total_reg, wanted_total_next;
    logic [16:0] weakest_reg, weakest_next;
    logic        urge_seen_reg, urge_seen_next;
    logic [16:0] window_count_reg, window_count_next;
    logic        result_valid_reg, result_valid_next;

    // Working values of the current sample, window or final score.
    sample_t     item_reg, item_next;
    logic [31:0] got_reg, got_next;
    logic [32:0] want_reg, want_next;
    logic [31:0] met_reg, met_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] effort_reg, effort_next;
    logic [31:0] murge_reg, murge_next;
    logic [16:0] match_reg, match_next;
    result_t     pend_reg, pend_next;
    result_t     result_reg, result_next;

    // Shared units.
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_CNT_W-1:0] div_nbits;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [32:0]          mul_a;
    logic [31:0]          mul_b;
    logic [64:0]          mul_p;

    // Derived values.
    logic [15:0]        per;
    logic [15:0]        fill_inc;
    logic [31:0]        av;
    logic [32:0]        tsum;
    logic [32:0]        tmag;
    logic [16:0]        uc;
    logic [64:0]        eff_sum;
    logic [32:0]        want_c;
    logic [16:0]        frac;
    logic [47:0]        pen;
    logic signed [49:0] score_w;
    logic [31:0]        score_sat;
    logic               in_budget;
    logic               limited;
    logic               emit_go;
    logic               sample_take;

    localparam logic signed [49:0] SCORE_MIN = -50'sd2147483648;
    localparam logic signed [49:0] SCORE_MAX = 50'sd2147483647;

    mus_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .nbits (div_nbits),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    mus_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // A window length of zero behaves as one sample.
    assign per      = (win_samples_reg == 16'd0) ? 16'd1 : win_samples_reg;
    assign fill_inc = window_fill_reg + 16'd1;

    assign av = item_reg.angular_velocity[31] ?
                (~item_reg.angular_velocity + 32'd1) : item_reg.angular_velocity;

    // The torque sum needs 33 bits; its magnitude can reach two to the 32nd.
    assign tsum = {item_reg.active_drive_torque[31], item_reg.active_drive_torque}
                + {item_reg.posture_torque[31], item_reg.posture_torque};
    assign tmag = tsum[32] ? (~tsum + 33'd1) : tsum;

    // Urge is clamped to the range zero to one.
    always_comb
    begin
        if (item_reg.urge_level[31])
            uc = '0;
        else if (item_reg.urge_level > 32'sd65536)
            uc = ONE_Q;
        else
            uc = item_reg.urge_level[16:0];
    end

    assign eff_sum = {1'b0, effort_total_reg} + {17'd0, mul_p[63:16]};
    assign want_c  = mul_p[48:16];
    assign frac    = cap_one(div_quo);
    assign pen     = mul_p[63:16];
    assign score_w = $signed(50'(match_reg)) - $signed(50'(pen));

    always_comb
    begin
        if (score_w < SCORE_MIN)
            score_sat = 32'h8000_0000;
        else if (score_w > SCORE_MAX)
            score_sat = 32'h7FFF_FFFF;
        else
            score_sat = score_w[31:0];
    end

    assign in_budget = (effort_reg <= effort_limit_reg);
    assign limited   = urge_seen_reg && ((27'(match_reg) * MATCH_SCALE) < MATCH_BAR)
                     && !in_budget;
    assign emit_go   = !result_valid_reg || result.ready;

    // A transfer that is counted into the run, as opposed to one dropped past the limit.
    assign sample_take = sample.valid && sample.ready && (sample_total_reg < MAX_SAMPLES);

    // Sequencer: next state, run state updates and shared unit operands.
    always_comb
    begin
        state_next           = state_reg;
        velocity_total_next  = velocity_total_reg;
        effort_total_next    = effort_total_reg;
        sample_total_next    = sample_total_reg;
        window_fill_next     = window_fill_reg;
        window_velocity_next = window_velocity_reg;
        window_urge_next     = window_urge_reg;
        met_total_next       = met_total_reg;
        wanted_total_next    = wanted_total_reg;
        weakest_next         = weakest_reg;
        urge_seen_next       = urge_seen_reg;
        window_count_next    = window_count_reg;
        item_next            = item_reg;
        got_next             = got_reg;
        want_next            = want_reg;
        met_next             = met_reg;
        rate_next            = rate_reg;
        effort_next          = effort_reg;
        murge_next           = murge_reg;
        match_next           = match_reg;
        pend_next            = pend_reg;
        result_next          = result_reg;
        result_valid_next    = result_valid_reg && !result.ready;
        div_start            = 1'b0;
        div_num              = '0;
        div_nbits            = '0;
        div_den              = '0;
        mul_a                = '0;
        mul_b                = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    item_next = sample.data;
                    // Past the sample limit a sample is dropped, but its final flag counts.
                    if (sample_total_reg < MAX_SAMPLES)
                        state_next = ST_ACC;
                    else if (sample.data.final_sample)
                        state_next = ST_FIN_CHECK;
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_ACC:
            begin
                if (gravity_torque_reg != 32'd0)
                begin
                    div_start  = 1'b1;
                    div_num    = {tmag, 47'd0};
                    div_nbits  = 7'd49;
                    div_den    = {32'd0, gravity_torque_reg};
                    state_next = ST_TAU_WAIT;
                end
                else
                    state_next = ST_SUMS;
            end

            ST_TAU_WAIT:
            begin
                mul_a = {1'b0, sat32(div_quo)};
                mul_b = sat32(div_quo);
                if (div_done)
                    state_next = ST_TAU_ADD;
            end

            ST_TAU_ADD:
            begin
                effort_total_next = eff_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : eff_sum[63:0];
                state_next        = ST_SUMS;
            end

            ST_SUMS:
            begin
                velocity_total_next  = velocity_total_reg + 48'(av);
                sample_total_next    = sample_total_reg + 17'd1;
                window_velocity_next = window_velocity_reg + 48'(av);
                window_urge_next     = window_urge_reg + 33'(uc);
                window_fill_next     = fill_inc;
                if (fill_inc >= per)
                    state_next = ST_W_RNG;
                else if (item_reg.final_sample)
                    state_next = ST_FIN_CHECK;
                else
                    state_next = ST_IDLE;
            end

            ST_FIN_CHECK:
            begin
                // A partly filled window is scored before the run closes.
                if (window_fill_reg != 16'd0)
                    state_next = ST_W_RNG;
                else
                    state_next = ST_F_START;
            end

            ST_W_RNG:
            begin
                if (motion_range_reg == 32'd0)
                begin
                    got_next   = '0;
                    div_start  = 1'b1;
                    div_num    = {window_urge_reg, 47'd0};
                    div_nbits  = 7'd33;
                    div_den    = {48'd0, window_fill_reg};
                    state_next = ST_W_U_WAIT;
                end
                else
                begin
                    mul_a      = {17'd0, window_fill_reg};
                    mul_b      = motion_range_reg;
                    state_next = ST_W_GOT;
                end
            end

            ST_W_GOT:
            begin
                div_start  = 1'b1;
                div_num    = {window_velocity_reg, 32'd0};
                div_nbits  = 7'd64;
                div_den    = {15'd0, mul_p[48:0]};
                state_next = ST_W_GOT_WAIT;
            end

            ST_W_GOT_WAIT:
            begin
                if (div_done)
                begin
                    got_next   = sat32(div_quo);
                    div_start  = 1'b1;
                    div_num    = {window_urge_reg, 47'd0};
                    div_nbits  = 7'd33;
                    div_den    = {48'd0, window_fill_reg};
                    state_next = ST_W_U_WAIT;
                end
            end

            ST_W_U_WAIT:
            begin
                // Mean urge times peak urge; the mean never exceeds one.
                mul_a = {16'd0, div_quo[16:0]};
                mul_b = peak_urge_reg;
                if (div_done)
                    state_next = ST_W_MET;
            end

            ST_W_MET:
            begin
                want_next  = want_c;
                met_next   = ({1'b0, got_reg} < want_c) ? got_reg : want_c[31:0];
                mul_a      = want_c;
                mul_b      = {16'd0, window_fill_reg};
                state_next = ST_W_WANTN;
            end

            ST_W_WANTN:
            begin
                wanted_total_next = wanted_total_reg + mul_p[63:0];
                mul_a             = {1'b0, met_reg};
                mul_b             = {16'd0, window_fill_reg};
                state_next        = ST_W_METN;
            end

            ST_W_METN:
            begin
                met_total_next = met_total_reg + mul_p[63:0];
                if (want_reg != 33'd0)
                begin
                    div_start  = 1'b1;
                    div_num    = {met_reg, 48'd0};
                    div_nbits  = 7'd48;
                    div_den    = {31'd0, want_reg};
                    state_next = ST_W_FRAC_WAIT;
                end
                else
                    state_next = ST_W_END;
            end

            ST_W_FRAC_WAIT:
            begin
                if (div_done)
                begin
                    urge_seen_next = 1'b1;
                    if (frac < weakest_reg)
                        weakest_next = frac;
                    state_next = ST_W_END;
                end
            end

            ST_W_END:
            begin
                window_count_next    = window_count_reg + 17'd1;
                window_fill_next     = '0;
                window_velocity_next = '0;
                window_urge_next     = '0;
                state_next = item_reg.final_sample ? ST_FIN_CHECK : ST_IDLE;
            end

            ST_F_START:
            begin
                if (motion_range_reg == 32'd0 || sample_total_reg == 17'd0)
                begin
                    pend_next  = '0;
                    state_next = ST_F_EMIT;
                end
                else
                begin
                    mul_a      = {16'd0, sample_total_reg};
                    mul_b      = motion_range_reg;
                    state_next = ST_F_RATE;
                end
            end

            ST_F_RATE:
            begin
                div_start  = 1'b1;
                div_num    = {velocity_total_reg, 32'd0};
                div_nbits  = 7'd64;
                div_den    = {15'd0, mul_p[48:0]};
                state_next = ST_F_RATE_WAIT;
            end

            ST_F_RATE_WAIT:
            begin
                if (div_done)
                begin
                    rate_next = sat32(div_quo);
                    div_start = 1'b1;
                    div_nbits = 7'd64;
                    div_den   = {47'd0, sample_total_reg};
                    if (gravity_torque_reg != 32'd0)
                    begin
                        div_num    = {effort_total_reg, 16'd0};
                        state_next = ST_F_EFF_WAIT;
                    end
                    else
                    begin
                        effort_next = '0;
                        div_num     = {wanted_total_reg, 16'd0};
                        state_next  = ST_F_URGE_WAIT;
                    end
                end
            end

            ST_F_EFF_WAIT:
            begin
                if (div_done)
                begin
                    effort_next = sat32(div_quo);
                    div_start   = 1'b1;
                    div_num     = {wanted_total_reg, 16'd0};
                    div_nbits   = 7'd64;
                    div_den     = {47'd0, sample_total_reg};
                    state_next  = ST_F_URGE_WAIT;
                end
            end

            ST_F_URGE_WAIT:
            begin
                if (div_done)
                begin
                    murge_next = sat32(div_quo);
                    if (wanted_total_reg != 64'd0)
                    begin
                        div_start  = 1'b1;
                        div_num    = {met_total_reg, 16'd0};
                        div_nbits  = 7'd80;
                        div_den    = wanted_total_reg;
                        state_next = ST_F_MATCH_WAIT;
                    end
                    else
                    begin
                        match_next = '0;
                        state_next = ST_F_PEN;
                    end
                end
            end

            ST_F_MATCH_WAIT:
            begin
                if (div_done)
                begin
                    match_next = frac;
                    state_next = ST_F_PEN;
                end
            end

            ST_F_PEN:
            begin
                // Effort at or under budget multiplies by zero and costs nothing.
                mul_a      = {1'b0, penalty_weight_reg};
                mul_b      = (effort_reg > effort_limit_reg) ?
                             (effort_reg - effort_limit_reg) : 32'd0;
                state_next = ST_F_SCORE;
            end

            ST_F_SCORE:
            begin
                pend_next.achieved_rate    = rate_reg;
                pend_next.mean_effort      = effort_reg;
                pend_next.mean_urge        = murge_reg;
                pend_next.match_ratio      = match_reg;
                pend_next.weakest_fraction = urge_seen_reg ? weakest_reg : 17'd0;
                pend_next.within_budget    = in_budget;
                pend_next.budget_limited   = limited;
                pend_next.window_total     = window_count_reg;
                pend_next.penalized_score  = score_sat;
                state_next                 = ST_F_EMIT;
            end

            ST_F_EMIT:
            begin
                if (emit_go)
                begin
                    result_next          = pend_reg;
                    result_valid_next    = 1'b1;
                    velocity_total_next  = '0;
                    effort_total_next    = '0;
                    sample_total_next    = '0;
                    window_fill_next     = '0;
                    window_velocity_next = '0;
                    window_urge_next     = '0;
                    met_total_next       = '0;
                    wanted_total_next    = '0;
                    weakest_next         = ONE_Q;
                    urge_seen_next       = 1'b0;
                    window_count_next    = '0;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_samples_reg    <= 16'd100;
            motion_range_reg   <= 32'd205887;
            gravity_torque_reg <= 32'd65536;
            peak_urge_reg      <= 32'd65536;
            effort_limit_reg   <= 32'd65536;
            penalty_weight_reg <= 32'd655360;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WINDOW_SAMPLES: win_samples_reg    <= cfg.data[15:0];
                CFG_MOTION_RANGE:   motion_range_reg   <= cfg.data;
                CFG_GRAVITY_TORQUE: gravity_torque_reg <= cfg.data;
                CFG_PEAK_URGE:      peak_urge_reg      <= cfg.data;
                CFG_EFFORT_LIMIT:   effort_limit_reg   <= cfg.data;
                CFG_PENALTY_WEIGHT: penalty_weight_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            velocity_total_reg  <= '0;
            effort_total_reg    <= '0;
            sample_total_reg    <= '0;
            window_fill_reg     <= '0;
            window_velocity_reg <= '0;
            window_urge_reg     <= '0;
            met_total_reg       <= '0;
            wanted_total_reg    <= '0;
            weakest_reg         <= ONE_Q;
            urge_seen_reg       <= 1'b0;
            window_count_reg    <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            velocity_total_reg  <= velocity_total_next;
            effort_total_reg    <= effort_total_next;
            sample_total_reg    <= sample_total_next;
            window_fill_reg     <= window_fill_next;
            window_velocity_reg <= window_velocity_next;
            window_urge_reg     <= window_urge_next;
            met_total_reg       <= met_total_next;
            wanted_total_reg    <= wanted_total_next;
            weakest_reg         <= weakest_next;
            urge_seen_reg       <= urge_seen_next;
            window_count_reg    <= window_count_next;
            result_valid_reg    <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        got_reg    <= got_next;
        want_reg   <= want_next;
        met_reg    <= met_next;
        rate_reg   <= rate_next;
        effort_reg <= effort_next;
        murge_reg  <= murge_next;
        match_reg  <= match_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == ST_IDLE);
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // The sequencer only starts the divider once the previous division is finished.
    `MUS_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider started while busy")
    // Taking a counted sample moves the sequencer out of idle, so the next sample must wait.
    `MUS_ASSERT_NXT(a_busy_after_take, sample_take, !sample.ready, "sample taken while idle")
    // Handing over a score empties the run state and shows the result.
    `MUS_ASSERT_NXT(a_run_cleared, state_reg == ST_F_EMIT && emit_go, sample_total_reg == '0 && result.valid, "run not cleared")

endmodule

`default_nettype wire

// File: dv/motion_urge_match_scorer_top_tb.sv
// Testbench for the motion urge match scorer: directed table, random runs, score prediction.
`timescale 1ns / 1ps

module motion_urge_match_scorer_top_tb;
    import mus_pkg::*;

    localparam int PAUSE_CYCLES = 700;   // covers a window close plus a final sample
    localparam int HOLD_CYCLES = 3000;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 630;
    localparam logic [63:0] CAP32 = 64'hFFFF_FFFF;
    localparam logic [63:0] ONE64 = 64'd65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mus_cfg_if    cfg ();
    mus_sample_if sample ();
    mus_result_if result ();

    motion_urge_match_scorer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .sample (sample.sink),
        .result (result.source)
    );

    always #1 clk = ~clk;

    // Expected scores in arrival order.
    result_t score_queue[$];
    int      errors = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    bit      hold_req = 1'b0;
    int      quiet_cycles = 0;

    // Shadow registers and shadow run state of the scorer.
    logic [63:0] r_ws, r_range, r_grav, r_peak, r_limit, r_pen;
    logic [63:0] acc_vel, acc_eff, n_samples, fill, win_vel, win_urge;
    logic [63:0] met_sum, want_sum, weakest, n_windows;
    bit          urge_hit;

    // floor(num * 2^sh / den), capped; zero when den is zero.
    function automatic logic [63:0] scaled_quot(logic [63:0] num, int sh, logic [63:0] den,
                                                logic [63:0] cap);
        logic [127:0] q;
        if (den == 0)
            return 64'd0;
        q = ({64'd0, num} << sh) / {64'd0, den};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    task automatic clear_run_state();
        acc_vel = 0; acc_eff = 0; n_samples = 0; fill = 0; win_vel = 0; win_urge = 0;
        met_sum = 0; want_sum = 0; weakest = ONE64; urge_hit = 0; n_windows = 0;
    endtask

    task automatic load_defaults();
        r_ws = 100; r_range = 205887; r_grav = 65536;
        r_peak = 65536; r_limit = 65536; r_pen = 655360;
        clear_run_state();
    endtask

    task automatic score_window();
        logic [63:0] got, u, want, met, frac;
        if (fill == 0)
            return;
        got = (r_range != 0) ? scaled_quot(win_vel, FRAC_BITS, fill * r_range, CAP32) : 0;
        u = win_urge / fill;
        want = (u * r_peak) >> FRAC_BITS;
        met = (got < want) ? got : want;
        met_sum += met * fill;
        want_sum += want * fill;
        if (want > 0)
        begin
            frac = scaled_quot(met, FRAC_BITS, want, ONE64);
            urge_hit = 1;
            if (frac < weakest)
                weakest = frac;
        end
        n_windows++;
        fill = 0; win_vel = 0; win_urge = 0;
    endtask

    // Advances the shadow run by one sample; emitted is set on the final sample.
    task automatic predict_sample(input sample_t s, output bit emitted, output result_t r);
        logic [63:0] per, av, tq, tau, sq, uc, rate, eff, murge, match, pen;
        logic [64:0] sum;
        longint      ur, sc;
        bit          in_budget;
        per = (r_ws != 0) ? r_ws : 1;
        emitted = 0;
        r = '0;
        if (n_samples < 64'(MAX_SAMPLES))
        begin
            av = magnitude(longint'(s.angular_velocity));
            ur = longint'(s.urge_level);
            if (r_grav != 0)
            begin
                tq = magnitude(longint'(s.active_drive_torque) + longint'(s.posture_torque));
                tau = scaled_quot(tq, FRAC_BITS, r_grav, CAP32);
                sq = (tau * tau) >> FRAC_BITS;
                sum = {1'b0, acc_eff} + {1'b0, sq};
                acc_eff = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
            end
            uc = (ur < 0) ? 0 : ((64'(ur) > ONE64) ? ONE64 : 64'(ur));
            acc_vel += av;
            n_samples++;
            win_vel += av;
            win_urge += uc;
            fill++;
            if (fill >= per)
                score_window();
        end
        if (!s.final_sample)
            return;
        score_window();
        emitted = 1;
        if (r_range != 0 && n_samples != 0)
        begin
            rate = scaled_quot(acc_vel, FRAC_BITS, n_samples * r_range, CAP32);
            eff = (r_grav != 0) ? scaled_quot(acc_eff, 0, n_samples, CAP32) : 0;
            murge = scaled_quot(want_sum, 0, n_samples, CAP32);
            match = (want_sum != 0) ? scaled_quot(met_sum, FRAC_BITS, want_sum, ONE64) : 0;
            in_budget = (eff <= r_limit);
            pen = (eff > r_limit) ? ((r_pen * (eff - r_limit)) >> FRAC_BITS) : 0;
            sc = longint'(match) - longint'(pen);
            if (sc < -64'sd2147483648)
                sc = -64'sd2147483648;
            if (sc > 64'sd2147483647)
                sc = 64'sd2147483647;
            r.achieved_rate = rate[31:0];
            r.mean_effort = eff[31:0];
            r.mean_urge = murge[31:0];
            r.match_ratio = match[16:0];
            r.weakest_fraction = urge_hit ? weakest[16:0] : 17'd0;
            r.within_budget = in_budget;
            r.budget_limited = urge_hit && (match * 1000 < 999 * ONE64) && !in_budget;
            r.window_total = n_windows[16:0];
            r.penalized_score = sc[31:0];
        end
        clear_run_state();
    endtask

    // Result checking: every transfer on the result channel meets the oldest expectation.
    function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (score_queue.size() == 0)
            begin
                $error("score transfer with no score expected");
                errors++;
            end
            else
            begin
                e = score_queue.pop_front();
                compare_field("achieved_rate", e.achieved_rate, result.data.achieved_rate);
                compare_field("mean_effort", e.mean_effort, result.data.mean_effort);
                compare_field("mean_urge", e.mean_urge, result.data.mean_urge);
                compare_field("match_ratio", e.match_ratio, result.data.match_ratio);
                compare_field("weakest_fraction", e.weakest_fraction,
                              result.data.weakest_fraction);
                compare_field("within_budget", e.within_budget, result.data.within_budget);
                compare_field("budget_limited", e.budget_limited, result.data.budget_limited);
                compare_field("window_total", e.window_total, result.data.window_total);
                compare_field("penalized_score", 64'(unsigned'(e.penalized_score)),
                              64'(unsigned'(result.data.penalized_score)));
            end
        end
    end

    // Watchdog: counts cycles in which no channel completes a transfer.
    always @(posedge clk)
    begin
        if ((cfg.valid && cfg.ready) || (sample.valid && sample.ready)
            || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, and one long hold-off on request.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                result.ready <= !(rx_idle_on && $urandom_range(99) < 19);
            end
        end
    end

    // Offers one sample and waits for its transfer. Valid stays high afterwards so that
    // back-to-back samples do not drop it; any idle cycle lowers it first.
    task automatic send_sample(input sample_t s, input bit lit, input result_t lit_r);
        bit      emitted;
        result_t r;
        cfg.valid <= 1'b0;
        while (tx_idle_on && $urandom_range(99) < 19)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.data <= s;
        do
            @(posedge clk);
        while (!sample.ready);
        predict_sample(s, emitted, r);
        if (emitted)
            score_queue.push_back(lit ? lit_r : r);
    endtask

    // Lets the scorer drain and go idle before register writes.
    task automatic settle();
        sample.valid <= 1'b0;
        cfg.valid <= 1'b0;
        wait (score_queue.size() == 0);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    // Writes one register; valid is lowered by the next settle or sample.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_WINDOW_SAMPLES: r_ws = {48'd0, value[15:0]};
            CFG_MOTION_RANGE:   r_range = {32'd0, value};
            CFG_GRAVITY_TORQUE: r_grav = {32'd0, value};
            CFG_PEAK_URGE:      r_peak = {32'd0, value};
            CFG_EFFORT_LIMIT:   r_limit = {32'd0, value};
            CFG_PENALTY_WEIGHT: r_pen = {32'd0, value};
            default: ;
        endcase
    endtask

    // Random Q16.16 value biased toward extremes and toward the unit range.
    function automatic logic [31:0] pick_q();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'($urandom_range(131072));
            4: return -32'($urandom_range(131072));
            5: return 32'($urandom_range(65536));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default:
            begin
                if (idx == CFG_WINDOW_SAMPLES)
                    return 32'($urandom_range(8));
                return 32'($urandom_range(1 << 20, 1 << 12));
            end
        endcase
    endfunction

    // Directed table: optional register write before the row, then one sample.
    typedef struct {
        bit                   wr;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        sample_t              s;
        bit                   lit;
        result_t              exp_r;
    } row_t;

    row_t    plan[$];
    result_t zero_score;
    result_t idle_score;

    task automatic add_row(bit wr, logic [CFG_IDX_W-1:0] idx, logic [31:0] val,
                           logic [31:0] av, logic [31:0] act, logic [31:0] post,
                           logic [31:0] urge, bit fin, bit lit, result_t exp_r);
        row_t row;
        row.wr = wr; row.idx = idx; row.val = val;
        row.s = sample_t'{av, act, post, urge, fin};
        row.lit = lit; row.exp_r = exp_r;
        plan.push_back(row);
    endtask

    initial
    begin
        int      sent;
        int      run_len;
        bit      hold_done;
        sample_t s;

        cfg.valid <= 1'b0;
        cfg.index <= CFG_WINDOW_SAMPLES;
        cfg.data <= '0;
        sample.valid <= 1'b0;
        sample.data <= '0;
        load_defaults();

        zero_score = '0;
        idle_score = '0;
        idle_score.within_budget = 1'b1;
        idle_score.window_total = 17'd1;

        // A still run right after reset scores one window of nothing.
        add_row(0, CFG_WINDOW_SAMPLES, 0, 0, 0, 0, 0, 1, 1, idle_score);
        // Field extremes.
        add_row(0, CFG_WINDOW_SAMPLES, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 0, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 1, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 1, 32'hFFFF_FFFF, 1, 65536, 1, 0, zero_score);
        // Zero window length acts as one sample per window.
        add_row(1, CFG_WINDOW_SAMPLES, 0, 65536, 100, 200, 32768, 0, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 1000, 65536, 0, 65537, 1, 0, zero_score);
        // Window shortened below the current fill closes on the next sample.
        add_row(1, CFG_WINDOW_SAMPLES, 3, 50000, 30000, 30000, 40000, 0, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 70000, 30000, 30000, 60000, 0, 0, zero_score);
        add_row(1, CFG_WINDOW_SAMPLES, 1, 20000, 0, 1000, 65536, 0, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 20000, 0, 1000, 65536, 1, 0, zero_score);
        // Zero range gives an all-zero score.
        add_row(1, CFG_MOTION_RANGE, 0, 12345, 999, 999, 65536, 0, 0, zero_score);
        add_row(0, CFG_WINDOW_SAMPLES, 0, 12345, 999, 999, 65536, 1, 1, zero_score);
        add_row(1, CFG_MOTION_RANGE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 65536, 1, 0,
                zero_score);
        // Zero gravity gives zero effort.
        add_row(1, CFG_GRAVITY_TORQUE, 0, 65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30000, 1, 0,
                zero_score);
        // Tiny gravity caps the normalized torque.
        add_row(1, CFG_GRAVITY_TORQUE, 1, 65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30000, 1, 0,
                zero_score);
        // Huge urge rate, no budget, maximal penalty: score saturates low.
        add_row(1, CFG_PEAK_URGE, 32'hFFFF_FFFF, 100, 32'h0100_0000, 0, 65536, 0, 0,
                zero_score);
        add_row(1, CFG_EFFORT_LIMIT, 0, 100, 32'h0100_0000, 0, 65536, 0, 0, zero_score);
        add_row(1, CFG_PENALTY_WEIGHT, 32'hFFFF_FFFF, 100, 32'h0100_0000, 0, 65536, 1, 0,
                zero_score);
        // No urge at all: weakest fraction reads zero.
        add_row(1, CFG_PEAK_URGE, 0, 5000, 0, 0, 65536, 1, 0, zero_score);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            send_sample(plan[i].s, plan[i].lit, plan[i].exp_r);
        end

        // Random runs: mostly short runs with small windows, registers moved between runs.
        settle();
        write_reg(CFG_WINDOW_SAMPLES, 2);
        write_reg(CFG_MOTION_RANGE, 65536);
        write_reg(CFG_GRAVITY_TORQUE, 131072);
        write_reg(CFG_PEAK_URGE, 65536);
        write_reg(CFG_EFFORT_LIMIT, 65536);
        write_reg(CFG_PENALTY_WEIGHT, 655360);
        sent = 0;
        hold_done = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(2) == 0)
            begin
                settle();
                repeat ($urandom_range(3, 1))
                begin
                    logic [CFG_IDX_W-1:0] idx;
                    idx = CFG_IDX_W'($urandom_range(5));
                    write_reg(idx, pick_reg(idx));
                end
            end
            // A stretch with no idling on either side.
            tx_idle_on = !(sent >= 300 && sent < 400);
            rx_idle_on = tx_idle_on;
            run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
            for (int k = 0; k < run_len; k++)
            begin
                if (!hold_done && sent >= 200)
                begin
                    hold_req = 1'b1;
                    hold_done = 1;
                end
                if (k == 1 && $urandom_range(9) == 0)
                begin
                    // Register write in the middle of a run.
                    settle();
                    write_reg(CFG_WINDOW_SAMPLES, pick_reg(CFG_WINDOW_SAMPLES));
                end
                s.angular_velocity = ($urandom_range(1)) ? pick_q()
                                                         : 32'($urandom_range(200000));
                s.active_drive_torque = pick_q();
                s.posture_torque = ($urandom_range(1)) ? pick_q() : 32'd0;
                s.urge_level = ($urandom_range(3) == 0) ? pick_q()
                                                        : 32'($urandom_range(65536));
                // Noise: an early final flag now and then breaks the run.
                s.final_sample = (k == run_len - 1) || ($urandom_range(29) == 0);
                send_sample(s, 0, zero_score);
                sent++;
            end
        end

        sample.valid <= 1'b0;
        cfg.valid <= 1'b0;
        wait (score_queue.size() == 0);
        repeat (PAUSE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/mus_pkg.sv
src/mus_sample_if.sv
src/mus_result_if.sv
src/mus_cfg_if.sv
src/mus_div.sv
src/mus_mul.sv
src/motion_urge_match_scorer_top.sv
dv/motion_urge_match_scorer_top_tb.sv
